/* src/scab_pkg.sv */
// shared types and constants for the span coverage alpha blender
`timescale 1ns / 1ps
`default_nettype none
package scab_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FILL_COLOR   = 3'd0,
    REG_FILL_MODE    = 3'd1,
    REG_BYTE_ORDER   = 3'd2,
    REG_PITCH_X      = 3'd3,
    REG_PITCH_Y      = 3'd4,
    REG_BASE_ADDRESS = 3'd5
  } reg_idx_t;

  // fill modes, the unused code behaves as per-pixel
  localparam logic [1:0] MODE_CONST       = 2'd0;
  localparam logic [1:0] MODE_CONST_ALPHA = 2'd1;

  localparam logic [7:0]  BYTE_FULL       = 8'hFF;
  localparam logic [7:0]  BYTE_ZERO       = 8'h00;
  localparam logic [31:0] PITCH_X_RESET   = 32'd3;

  typedef struct packed {
    logic [31:0]        fill_color;
    logic [1:0]         fill_mode;
    logic               byte_order;
    logic signed [5:0]  pitch_x;
    logic signed [15:0] pitch_y;
    logic [31:0]        base_address;
  } cfg_t;

  typedef struct packed {
    logic [11:0]     pixel_x;
    logic [11:0]     row_y;
    logic [7:0]      coverage;
    logic [31:0]     src_color;
    logic [2:0][7:0] dst;
    logic            last_in_row;
  } in_t;

  // after alpha scaling and address products
  typedef struct packed {
    logic signed [28:0] addr_y;
    logic signed [17:0] addr_x;
    logic [7:0]         alpha;
    logic [2:0][7:0]    src;
    logic [2:0][7:0]    dst;
    logic               copy;
    logic               we;
    logic               row_done;
  } s1_t;

  // after blend products and address sum
  typedef struct packed {
    logic [31:0]     addr;
    logic [2:0][7:0] delta;
    logic [2:0][7:0] src;
    logic [2:0][7:0] dst;
    logic            copy;
    logic            we;
    logic            row_done;
  } s2_t;

  typedef struct packed {
    logic [31:0]     addr;
    logic [2:0][7:0] bytes;
    logic            we;
    logic            row_done;
  } s3_t;

endpackage
`default_nettype wire

/* src/scab_cfg.sv */
// configuration registers of the blender
`timescale 1ns / 1ps
`default_nettype none
module scab_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  output scab_pkg::cfg_t     cfg
);
  import scab_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_FILL_COLOR:   cfg_nxt.fill_color   = cfg_data;
        REG_FILL_MODE:    cfg_nxt.fill_mode    = cfg_data[1:0];
        REG_BYTE_ORDER:   cfg_nxt.byte_order   = cfg_data[0];
        REG_PITCH_X:      cfg_nxt.pitch_x      = cfg_data[5:0];
        REG_PITCH_Y:      cfg_nxt.pitch_y      = cfg_data[15:0];
        REG_BASE_ADDRESS: cfg_nxt.base_address = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fill_color   <= '0;
      cfg_r.fill_mode    <= MODE_CONST;
      cfg_r.byte_order   <= 1'b0;
      cfg_r.pitch_x      <= PITCH_X_RESET[5:0];
      cfg_r.pitch_y      <= '0;
      cfg_r.base_address <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

/* src/scab_stage1.sv */
// stage 1: mode decode, alpha scaling and address partial products
`timescale 1ns / 1ps
`default_nettype none
module scab_stage1 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire scab_pkg::cfg_t cfg,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire scab_pkg::in_t  up_data,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output scab_pkg::s1_t    dn_data
);
  import scab_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  s1_t         data_r;
  s1_t         data_nxt;
  logic [31:0] col;
  logic [7:0]  src_alpha;
  logic [7:0]  scale_in;
  logic [8:0]  scale_a1;
  logic [16:0] scale_prod;
  logic signed [12:0] y_s;
  logic signed [12:0] x_s;

  assign up_ready = !valid_r || dn_ready;

  // pick color and alpha by mode
  always_comb begin
    src_alpha  = up_data.src_color[31:24];
    col        = up_data.src_color;
    scale_in   = src_alpha;
    data_nxt   = data_r;
    case (cfg.fill_mode)
      MODE_CONST: begin
        col      = cfg.fill_color;
        scale_in = cfg.fill_color[31:24];
      end
      MODE_CONST_ALPHA: begin
        col      = cfg.fill_color;
        scale_in = cfg.fill_color[31:24];
      end
      default: begin
        col      = up_data.src_color;
        scale_in = src_alpha;
      end
    endcase
    scale_a1   = {1'b0, scale_in} + 9'd1;
    scale_prod = scale_a1 * {9'd0, up_data.coverage};

    data_nxt.alpha = (cfg.fill_mode == MODE_CONST) ? up_data.coverage : scale_prod[15:8];
    data_nxt.copy  = 1'b0;
    data_nxt.we    = 1'b1;
    if (cfg.fill_mode == MODE_CONST) begin
      data_nxt.copy = (up_data.coverage == BYTE_FULL);
    end else if (cfg.fill_mode != MODE_CONST_ALPHA) begin
      data_nxt.copy = (src_alpha == BYTE_FULL) && (up_data.coverage == BYTE_FULL);
      data_nxt.we   = (src_alpha != BYTE_ZERO);
    end

    // source bytes in memory order
    data_nxt.src[1] = col[15:8];
    data_nxt.src[0] = cfg.byte_order ? col[7:0]   : col[23:16];
    data_nxt.src[2] = cfg.byte_order ? col[23:16] : col[7:0];
    data_nxt.dst      = up_data.dst;
    data_nxt.row_done = up_data.last_in_row;

    // address partial products
    y_s = $signed({1'b0, up_data.row_y});
    x_s = $signed({1'b0, up_data.pixel_x});
    data_nxt.addr_y = 29'(y_s * cfg.pitch_y);
    data_nxt.addr_x = 18'(x_s * cfg.pitch_x);
  end

  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
`default_nettype wire

/* src/scab_stage2.sv */
// stage 2: per-channel blend products and address sum
`timescale 1ns / 1ps
`default_nettype none
module scab_stage2 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire scab_pkg::cfg_t cfg,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire scab_pkg::s1_t  up_data,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output scab_pkg::s2_t    dn_data
);
  import scab_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  s2_t         data_r;
  s2_t         data_nxt;
  logic signed [9:0]  a1_s;
  logic signed [9:0]  diff [3];
  logic signed [19:0] prod [3];

  assign up_ready = !valid_r || dn_ready;

  // (a + 1) * (s - d), keep the bits above the shift
  always_comb begin
    a1_s = $signed({2'b00, up_data.alpha} + 10'd1);
    data_nxt = data_r;
    for (int i = 0; i < 3; i++) begin
      diff[i] = $signed({2'b00, up_data.src[i]}) - $signed({2'b00, up_data.dst[i]});
      prod[i] = 20'(a1_s * diff[i]);
      data_nxt.delta[i] = prod[i][15:8];
    end
    data_nxt.addr = cfg.base_address + 32'(up_data.addr_y) + 32'(up_data.addr_x);
    data_nxt.src      = up_data.src;
    data_nxt.dst      = up_data.dst;
    data_nxt.copy     = up_data.copy;
    data_nxt.we       = up_data.we;
    data_nxt.row_done = up_data.row_done;
  end

  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
`default_nettype wire

/* src/scab_stage3.sv */
// stage 3: final add, byte select and output register
`timescale 1ns / 1ps
`default_nettype none
module scab_stage3 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire scab_pkg::s2_t  up_data,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output scab_pkg::s3_t    dn_data
);
  import scab_pkg::*;

  logic valid_r;
  logic valid_nxt;
  s3_t  data_r;
  s3_t  data_nxt;

  assign up_ready = !valid_r || dn_ready;

  // skip keeps dst, copy takes src, else d plus the scaled difference
  always_comb begin
    data_nxt = data_r;
    for (int i = 0; i < 3; i++) begin
      if (!up_data.we) begin
        data_nxt.bytes[i] = up_data.dst[i];
      end else if (up_data.copy) begin
        data_nxt.bytes[i] = up_data.src[i];
      end else begin
        data_nxt.bytes[i] = up_data.dst[i] + up_data.delta[i];
      end
    end
    data_nxt.addr     = up_data.addr;
    data_nxt.we       = up_data.we;
    data_nxt.row_done = up_data.row_done;
  end

  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
`default_nettype wire

/* src/span_coverage_alpha_blend_rgb24_top.sv */
// each accepted input passes through the stage 1, stage 2 and stage 3 registers
// throughput: one pixel per cycle while not stalled, set by the three-stage pipeline
// each stage holds under back-pressure, so stalls lose and repeat nothing
// reset: synchronous active-low rst_n empties the pipeline and returns the
// registers to fill_mode 0, pitch_x 3 and all other registers 0
`timescale 1ns / 1ps
`default_nettype none
module span_coverage_alpha_blend_rgb24_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [11:0] in_pixel_x,
  input  wire logic [11:0] in_row_y,
  input  wire logic [7:0]  in_coverage,
  input  wire logic [31:0] in_src_color,
  input  wire logic [7:0]  in_dst_byte0,
  input  wire logic [7:0]  in_dst_byte1,
  input  wire logic [7:0]  in_dst_byte2,
  input  wire logic        in_last_in_row,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_byte_address,
  output logic [7:0]       out_byte0,
  output logic [7:0]       out_byte1,
  output logic [7:0]       out_byte2,
  output logic             out_write_enable,
  output logic             out_row_done
);
  import scab_pkg::*;

  cfg_t cfg;
  in_t  in_data;
  s1_t  s1_data;
  s2_t  s2_data;
  s3_t  s3_data;
  logic s1_valid;
  logic s1_ready;
  logic s2_valid;
  logic s2_ready;

  // input transaction payload
  always_comb begin
    in_data.pixel_x     = in_pixel_x;
    in_data.row_y       = in_row_y;
    in_data.coverage    = in_coverage;
    in_data.src_color   = in_src_color;
    in_data.dst[0]      = in_dst_byte0;
    in_data.dst[1]      = in_dst_byte1;
    in_data.dst[2]      = in_dst_byte2;
    in_data.last_in_row = in_last_in_row;
  end

  scab_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scab_stage1 u_stage1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  scab_stage2 u_stage2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  scab_stage3 u_stage3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (s3_data)
  );

  // result transaction payload
  assign out_byte_address = s3_data.addr;
  assign out_byte0        = s3_data.bytes[0];
  assign out_byte1        = s3_data.bytes[1];
  assign out_byte2        = s3_data.bytes[2];
  assign out_write_enable = s3_data.we;
  assign out_row_done     = s3_data.row_done;

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// self-checking testbench for the span coverage alpha blender
`timescale 1ns / 1ps
module tb_top;
  import scab_pkg::*;

  // fill mode codes not named in the package
  localparam logic [1:0] MODE_PIXEL  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int PIPE_LATENCY  = 3;
  localparam int SETTLE_CYCLES = 4 * PIPE_LATENCY;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int MAX_REPORTS   = 40;
  localparam int PHASE_COUNT   = 10;
  localparam int PHASE_ITEMS   = 125;

  typedef struct packed {
    logic [11:0]     pixel_x;
    logic [11:0]     row_y;
    logic [7:0]      coverage;
    logic [31:0]     src_color;
    logic [2:0][7:0] dst;
    logic            last_in_row;
  } pixel_req_t;

  typedef struct packed {
    logic [31:0]     byte_address;
    logic [2:0][7:0] bytes;
    logic            write_enable;
    logic            row_done;
  } pixel_wr_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_PERIODIC,
    READY_SPARSE
  } ready_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [11:0] in_pixel_x;
  logic [11:0] in_row_y;
  logic [7:0]  in_coverage;
  logic [31:0] in_src_color;
  logic [7:0]  in_dst_byte0;
  logic [7:0]  in_dst_byte1;
  logic [7:0]  in_dst_byte2;
  logic        in_last_in_row;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_byte_address;
  logic [7:0]  out_byte0;
  logic [7:0]  out_byte1;
  logic [7:0]  out_byte2;
  logic        out_write_enable;
  logic        out_row_done;

  // blender register copy and expected framebuffer writes
  cfg_t        blend_cfg;
  pixel_wr_t   pending_writes[$];
  int          error_count   = 0;
  int          cycle_count   = 0;
  int          burst_left    = 0;
  bit          steady_sender = 1'b0;
  int          ready_cycle   = 0;
  ready_mode_t ready_mode    = READY_ALWAYS;

  span_coverage_alpha_blend_rgb24_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_x       (in_pixel_x),
    .in_row_y         (in_row_y),
    .in_coverage      (in_coverage),
    .in_src_color     (in_src_color),
    .in_dst_byte0     (in_dst_byte0),
    .in_dst_byte1     (in_dst_byte1),
    .in_dst_byte2     (in_dst_byte2),
    .in_last_in_row   (in_last_in_row),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte_address (out_byte_address),
    .out_byte0        (out_byte0),
    .out_byte1        (out_byte1),
    .out_byte2        (out_byte2),
    .out_write_enable (out_write_enable),
    .out_row_done     (out_row_done)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ((a + 1) * c) >> 8
  function automatic logic [7:0] scale_alpha(input logic [7:0] a, input logic [7:0] c);
    return 8'(((int'(a) + 1) * int'(c)) >> 8);
  endfunction

  // d + floor((a + 1) * (s - d) / 256)
  function automatic logic [7:0] lerp_byte(input logic [7:0] a, input logic [7:0] s,
                                           input logic [7:0] d);
    int prod;
    prod = (int'(a) + 1) * (int'(s) - int'(d));
    return 8'(int'(d) + (prod >>> 8));
  endfunction

  // expected framebuffer write for one pixel under the given registers
  function automatic pixel_wr_t blend_pixel(input pixel_req_t p, input cfg_t c);
    pixel_wr_t       r;
    logic [31:0]     col;
    logic [7:0]      alpha;
    logic [7:0]      src_alpha;
    logic            copy;
    logic [2:0][7:0] sb;
    logic [31:0]     px32;
    logic [31:0]     py32;
    r.write_enable = 1'b1;
    copy = 1'b0;
    src_alpha = p.src_color[31:24];
    case (c.fill_mode)
      MODE_CONST: begin
        col = c.fill_color;
        alpha = p.coverage;
        copy = (p.coverage == BYTE_FULL);
      end
      MODE_CONST_ALPHA: begin
        col = c.fill_color;
        alpha = scale_alpha(c.fill_color[31:24], p.coverage);
      end
      default: begin
        col = p.src_color;
        alpha = scale_alpha(src_alpha, p.coverage);
        copy = (src_alpha == BYTE_FULL) && (p.coverage == BYTE_FULL);
        r.write_enable = (src_alpha != BYTE_ZERO);
      end
    endcase
    // source bytes in memory order
    sb[1] = col[15:8];
    sb[0] = c.byte_order ? col[7:0] : col[23:16];
    sb[2] = c.byte_order ? col[23:16] : col[7:0];
    for (int i = 0; i < 3; i++) begin
      if (!r.write_enable) r.bytes[i] = p.dst[i];
      else if (copy) r.bytes[i] = sb[i];
      else r.bytes[i] = lerp_byte(alpha, sb[i], p.dst[i]);
    end
    px32 = {{26{c.pitch_x[5]}}, c.pitch_x};
    py32 = {{16{c.pitch_y[15]}}, c.pitch_y};
    r.byte_address = c.base_address + {20'd0, p.row_y} * py32 + {20'd0, p.pixel_x} * px32;
    r.row_done = p.last_in_row;
    return r;
  endfunction

  function automatic pixel_req_t make_pixel(input logic [11:0] x, input logic [11:0] y,
                                            input logic [7:0] cov, input logic [31:0] src,
                                            input logic [7:0] d0, input logic [7:0] d1,
                                            input logic [7:0] d2, input logic last);
    pixel_req_t p;
    p.pixel_x = x;
    p.row_y = y;
    p.coverage = cov;
    p.src_color = src;
    p.dst[0] = d0;
    p.dst[1] = d1;
    p.dst[2] = d2;
    p.last_in_row = last;
    return p;
  endfunction

  // zero, full or anything in between
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 3))
      0: return BYTE_ZERO;
      1: return BYTE_FULL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.fill_color = {pick_level(), 24'($urandom)};
    c.fill_mode = 2'($urandom_range(0, 3));
    c.byte_order = 1'($urandom_range(0, 1));
    c.pitch_x = ($urandom_range(0, 3) == 0) ? 6'($urandom)
                                            : 6'(int'($urandom_range(0, 32)) - 16);
    c.pitch_y = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                            : 16'(int'($urandom_range(0, 64)) - 32);
    c.base_address = $urandom;
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // hold the sender until every expected write has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FILL_COLOR:   blend_cfg.fill_color = value;
      REG_FILL_MODE:    blend_cfg.fill_mode = value[1:0];
      REG_BYTE_ORDER:   blend_cfg.byte_order = value[0];
      REG_PITCH_X:      blend_cfg.pitch_x = value[5:0];
      REG_PITCH_Y:      blend_cfg.pitch_y = value[15:0];
      REG_BASE_ADDRESS: blend_cfg.base_address = value;
      default: ;
    endcase
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(REG_FILL_COLOR, c.fill_color);
    write_reg(REG_FILL_MODE, {30'd0, c.fill_mode});
    write_reg(REG_BYTE_ORDER, {31'd0, c.byte_order});
    write_reg(REG_PITCH_X, {26'd0, c.pitch_x});
    write_reg(REG_PITCH_Y, {16'd0, c.pitch_y});
    write_reg(REG_BASE_ADDRESS, c.base_address);
  endtask

  // bursts of random length with random gaps, none while steady
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_sender ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // one input transaction, expectation recorded at acceptance
  task automatic send_pixel(input pixel_req_t p);
    pace_sender();
    in_valid <= 1'b1;
    in_pixel_x <= p.pixel_x;
    in_row_y <= p.row_y;
    in_coverage <= p.coverage;
    in_src_color <= p.src_color;
    in_dst_byte0 <= p.dst[0];
    in_dst_byte1 <= p.dst[1];
    in_dst_byte2 <= p.dst[2];
    in_last_in_row <= p.last_in_row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_writes.push_back(blend_pixel(p, blend_cfg));
  endtask

  // constant fill: reset registers first, then copy and coverage blends
  task automatic test_const_mode();
    send_pixel(make_pixel(12'hFFF, 12'hFFF, BYTE_FULL, $urandom, 8'h00, 8'h00, 8'h00, 1'b1));
    write_reg(REG_FILL_COLOR, 32'h12A0_B0C0);
    send_pixel(make_pixel(12'd0, 12'd0, BYTE_ZERO, 32'h0, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(make_pixel(12'd7, 12'd1, 8'h80, 32'hFFFF_FFFF, 8'h10, 8'hF0, 8'h55, 1'b0));
    send_pixel(make_pixel(12'd8, 12'd1, BYTE_FULL, 32'h0, 8'hFF, 8'h00, 8'hAA, 1'b1));
  endtask

  // constant color with fill alpha scaled by coverage, never a plain copy
  task automatic test_const_alpha_mode();
    write_reg(REG_FILL_MODE, {30'd0, MODE_CONST_ALPHA});
    write_reg(REG_FILL_COLOR, 32'hFF40_80C0);
    send_pixel(make_pixel(12'd1, 12'd2, BYTE_FULL, 32'h0, 8'h00, 8'hFF, 8'h7F, 1'b0));
    send_pixel(make_pixel(12'd2, 12'd2, BYTE_ZERO, 32'h0, 8'hFF, 8'h00, 8'h80, 1'b0));
    write_reg(REG_FILL_COLOR, 32'h00FF_FFFF);
    send_pixel(make_pixel(12'd3, 12'd2, BYTE_FULL, 32'h0, 8'h00, 8'h00, 8'h00, 1'b1));
  endtask

  // per-pixel source: skip, opaque copy, and scaled blends
  task automatic test_pixel_mode();
    write_reg(REG_FILL_MODE, {30'd0, MODE_PIXEL});
    send_pixel(make_pixel(12'd5, 12'd9, BYTE_FULL, 32'h00FF_FFFF, 8'h12, 8'h34, 8'h56, 1'b0));
    send_pixel(make_pixel(12'd6, 12'd9, BYTE_FULL, 32'hFF11_2233, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(make_pixel(12'd7, 12'd9, 8'hFE, 32'hFF11_2233, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(make_pixel(12'd8, 12'd9, BYTE_ZERO, 32'h80FF_0000, 8'h00, 8'hFF, 8'hFF, 1'b0));
    send_pixel(make_pixel(12'd9, 12'd9, BYTE_FULL, 32'h01FF_00FF, 8'h80, 8'h80, 8'h80, 1'b1));
  endtask

  // the spare mode code acts as per-pixel
  task automatic test_unused_mode();
    write_reg(REG_FILL_MODE, {30'd0, MODE_UNUSED});
    send_pixel(make_pixel(12'd1, 12'd1, BYTE_FULL, 32'h00AB_CDEF, 8'h01, 8'h02, 8'h03, 1'b0));
    send_pixel(make_pixel(12'd2, 12'd1, BYTE_FULL, 32'hFFAB_CDEF, 8'h01, 8'h02, 8'h03, 1'b1));
  endtask

  // swapped red and blue in memory
  task automatic test_byte_order();
    write_reg(REG_FILL_MODE, {30'd0, MODE_CONST});
    write_reg(REG_BYTE_ORDER, 32'd1);
    write_reg(REG_FILL_COLOR, 32'h00C0_8040);
    send_pixel(make_pixel(12'd3, 12'd4, BYTE_FULL, 32'h0, 8'h00, 8'h00, 8'h00, 1'b0));
    send_pixel(make_pixel(12'd4, 12'd4, 8'h40, 32'h0, 8'hFF, 8'h00, 8'h80, 1'b1));
  endtask

  // pitch and base extremes, address wrap
  task automatic test_address_extremes();
    write_reg(REG_BYTE_ORDER, 32'd0);
    write_reg(REG_PITCH_X, 32'(-16));
    write_reg(REG_PITCH_Y, 32'(-32768));
    write_reg(REG_BASE_ADDRESS, 32'd0);
    send_pixel(make_pixel(12'hFFF, 12'hFFF, BYTE_FULL, 32'h0, 8'h00, 8'h00, 8'h00, 1'b1));
    write_reg(REG_PITCH_X, 32'd16);
    write_reg(REG_PITCH_Y, 32'd32767);
    write_reg(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
    send_pixel(make_pixel(12'hFFF, 12'hFFF, BYTE_FULL, 32'h0, 8'h00, 8'h00, 8'h00, 1'b1));
    // patterns outside the nominal pitch range
    write_reg(REG_PITCH_X, 32'd31);
    send_pixel(make_pixel(12'd1, 12'd0, BYTE_FULL, 32'h0, 8'h00, 8'h00, 8'h00, 1'b0));
    write_reg(REG_PITCH_X, 32'h0000_0020);
    write_reg(REG_BASE_ADDRESS, 32'h8000_0000);
    send_pixel(make_pixel(12'd1, 12'd1, BYTE_FULL, 32'h0, 8'h00, 8'h00, 8'h00, 1'b0));
  endtask

  // mostly rasterizer-like spans, some lone noise pixels and broken row markers
  task automatic run_random_items(input int count);
    int          sent;
    int          span_len;
    logic [11:0] x0;
    logic [11:0] y;
    logic [7:0]  cov;
    pixel_req_t  p;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 8) begin
        span_len = $urandom_range(1, 12);
        x0 = 12'($urandom);
        y = 12'($urandom);
        for (int i = 0; i < span_len && sent < count; i++) begin
          if (i == 0 || i == span_len - 1) cov = pick_level();
          else cov = ($urandom_range(0, 7) == 0) ? 8'($urandom) : BYTE_FULL;
          p = make_pixel(x0 + 12'(i), y, cov, {pick_level(), 24'($urandom)}, 8'($urandom),
                         8'($urandom), 8'($urandom), i == span_len - 1);
          if ($urandom_range(0, 15) == 0) p.last_in_row = ~p.last_in_row;
          send_pixel(p);
          sent++;
        end
      end else begin
        p = make_pixel(12'($urandom), 12'($urandom), 8'($urandom), $urandom, 8'($urandom),
                       8'($urandom), 8'($urandom), 1'($urandom));
        send_pixel(p);
        sent++;
      end
    end
  endtask

  // register phases: maximum extreme, minimum extreme, then random settings
  task automatic test_random();
    cfg_t c;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph == 0)
        c = '{fill_color: 32'hFFFF_FFFF, fill_mode: MODE_UNUSED, byte_order: 1'b1,
              pitch_x: 6'h1F, pitch_y: 16'h7FFF, base_address: 32'hFFFF_FFFF};
      else if (ph == 1)
        c = '{fill_color: 32'h0, fill_mode: MODE_CONST, byte_order: 1'b0,
              pitch_x: 6'h20, pitch_y: 16'h8000, base_address: 32'h0};
      else
        c = random_cfg();
      apply_config(c);
      steady_sender = (ph % 4 == 2);
      if (ph == 4) begin
        run_random_items(PHASE_ITEMS / 2);
        drain_results();
        run_random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        run_random_items(PHASE_ITEMS);
      end
    end
    steady_sender = 1'b0;
  endtask

  // receiver back-pressure, in one of four patterns chosen again at random
  always @(posedge clk) begin
    ready_cycle <= ready_cycle + 1;
    if (ready_cycle % 96 == 0) ready_mode <= ready_mode_t'($urandom_range(0, 3));
    case (ready_mode)
      READY_ALWAYS:   out_ready <= 1'b1;
      READY_COIN:     out_ready <= 1'($urandom_range(0, 1));
      READY_PERIODIC: out_ready <= (ready_cycle % 4) != 3;
      default:        out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // compare each result transaction with the oldest expected write
  always @(posedge clk) begin : check_results
    pixel_wr_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected result at address %h", out_byte_address));
      end else begin
        want = pending_writes.pop_front();
        if (out_byte_address !== want.byte_address)
          report_mismatch($sformatf("byte_address got %h expected %h",
                                    out_byte_address, want.byte_address));
        if (out_byte0 !== want.bytes[0])
          report_mismatch($sformatf("out_byte0 got %h expected %h", out_byte0, want.bytes[0]));
        if (out_byte1 !== want.bytes[1])
          report_mismatch($sformatf("out_byte1 got %h expected %h", out_byte1, want.bytes[1]));
        if (out_byte2 !== want.bytes[2])
          report_mismatch($sformatf("out_byte2 got %h expected %h", out_byte2, want.bytes[2]));
        if (out_write_enable !== want.write_enable)
          report_mismatch($sformatf("write_enable got %b expected %b",
                                    out_write_enable, want.write_enable));
        if (out_row_done !== want.row_done)
          report_mismatch($sformatf("row_done got %b expected %b", out_row_done, want.row_done));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL span_coverage_alpha_blend_rgb24_top");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_FILL_COLOR;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_pixel_x <= '0;
    in_row_y <= '0;
    in_coverage <= '0;
    in_src_color <= '0;
    in_dst_byte0 <= '0;
    in_dst_byte1 <= '0;
    in_dst_byte2 <= '0;
    in_last_in_row <= 1'b0;
    blend_cfg = '{fill_color: 32'h0, fill_mode: MODE_CONST, byte_order: 1'b0,
                  pitch_x: PITCH_X_RESET[5:0], pitch_y: 16'h0, base_address: 32'h0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_const_mode();
    test_const_alpha_mode();
    test_pixel_mode();
    test_unused_mode();
    test_byte_order();
    test_address_extremes();
    test_random();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) $display("PASS span_coverage_alpha_blend_rgb24_top");
    else $display("FAIL span_coverage_alpha_blend_rgb24_top");
    $finish;
  end

endmodule

/* filelist.f */
src/scab_pkg.sv
src/scab_cfg.sv
src/scab_stage1.sv
src/scab_stage2.sv
src/scab_stage3.sv
src/span_coverage_alpha_blend_rgb24_top.sv
sim/tb_top.sv
